FILE: sv/bsiu_pkg.sv
// package for the branch and stack instruction unit
// holds the word types, opcode codes and cycle counts; depends on nothing
package bsiu_pkg;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] prog_counter;
    logic [15:0] stack_ptr;
    logic        zero_flag;
    logic        carry_flag;
    logic [15:0] immediate_word;
    logic [15:0] stack_word;
    logic [15:0] pair_af;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
  } instr_t;

  typedef struct packed {
    logic        recognized;
    logic [15:0] next_pc;
    logic        pc_final;
    logic [15:0] next_sp;
    logic        stack_write;
    logic [15:0] write_word;
    logic        pair_load;
    logic [1:0]  pair_select;
    logic [15:0] pair_value;
    logic [5:0]  cycle_count;
    logic        irq_enable_set;
  } result_t;

  // exact opcodes
  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_JR     = 8'h18;
  localparam logic [7:0] OP_JP     = 8'hc3;
  localparam logic [7:0] OP_CALL   = 8'hcd;
  localparam logic [7:0] OP_RET    = 8'hc9;
  localparam logic [7:0] OP_RETI   = 8'hd9;
  localparam logic [7:0] OP_JP_HL  = 8'he9;

  // opcode groups, matched under a mask
  localparam logic [7:0] CC_MASK   = 8'he7;
  localparam logic [7:0] OP_JR_CC  = 8'h20;
  localparam logic [7:0] OP_JP_CC  = 8'hc2;
  localparam logic [7:0] OP_CALL_CC = 8'hc4;
  localparam logic [7:0] OP_RET_CC = 8'hc0;
  localparam logic [7:0] RST_MASK  = 8'hc7;
  localparam logic [7:0] OP_RST    = 8'hc7;
  localparam logic [7:0] RST_VEC   = 8'h38;
  localparam logic [7:0] PAIR_MASK = 8'hcf;
  localparam logic [7:0] OP_PUSH   = 8'hc5;
  localparam logic [7:0] OP_POP    = 8'hc1;

  // condition codes in opcode bits 4:3
  localparam logic [1:0] CC_NZ = 2'd0;
  localparam logic [1:0] CC_Z  = 2'd1;
  localparam logic [1:0] CC_NC = 2'd2;
  localparam logic [1:0] CC_C  = 2'd3;

  // register pair codes in opcode bits 5:4
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_AF = 2'd3;

  localparam logic [5:0] CYC_4  = 6'd4;
  localparam logic [5:0] CYC_8  = 6'd8;
  localparam logic [5:0] CYC_12 = 6'd12;
  localparam logic [5:0] CYC_16 = 6'd16;
  localparam logic [5:0] CYC_20 = 6'd20;
  localparam logic [5:0] CYC_24 = 6'd24;
  localparam logic [5:0] CYC_32 = 6'd32;

endpackage

FILE: sv/bsiu_if.sv
// valid/ready channels for instruction words and result words
// standalone; field widths follow the words in bsiu_pkg
interface bsiu_instr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic [15:0] prog_counter;
  logic [15:0] stack_ptr;
  logic        zero_flag;
  logic        carry_flag;
  logic [15:0] immediate_word;
  logic [15:0] stack_word;
  logic [15:0] pair_af;
  logic [15:0] pair_bc;
  logic [15:0] pair_de;
  logic [15:0] pair_hl;

  modport source (
    output valid, opcode, prog_counter, stack_ptr, zero_flag, carry_flag,
           immediate_word, stack_word, pair_af, pair_bc, pair_de, pair_hl,
    input  ready
  );
  modport sink (
    input  valid, opcode, prog_counter, stack_ptr, zero_flag, carry_flag,
           immediate_word, stack_word, pair_af, pair_bc, pair_de, pair_hl,
    output ready
  );
endinterface

interface bsiu_result_if;
  logic        valid;
  logic        ready;
  logic        recognized;
  logic [15:0] next_pc;
  logic        pc_final;
  logic [15:0] next_sp;
  logic        stack_write;
  logic [15:0] write_word;
  logic        pair_load;
  logic [1:0]  pair_select;
  logic [15:0] pair_value;
  logic [5:0]  cycle_count;
  logic        irq_enable_set;

  modport source (
    output valid, recognized, next_pc, pc_final, next_sp, stack_write, write_word,
           pair_load, pair_select, pair_value, cycle_count, irq_enable_set,
    input  ready
  );
  modport sink (
    input  valid, recognized, next_pc, pc_final, next_sp, stack_write, write_word,
           pair_load, pair_select, pair_value, cycle_count, irq_enable_set,
    output ready
  );
endinterface

FILE: sv/branch_stack_instruction_unit_core.sv
// Branch and stack instruction unit. Takes one instruction word per cycle and
// returns one result word for each word that it accepts: the word is captured
// in an input register, decoded and executed by bsiu_exec in a single pass of
// short logic (a few 16-bit adders and selects), and captured in a result
// register. Sustained rate is one word per cycle; ready drops only when both
// registers hold words that the result side has not taken.
// depends on bsiu_pkg, bsiu_if and bsiu_exec
module branch_stack_instruction_unit_core (
  input  logic           clk,
  input  logic           rst,
  bsiu_instr_if.sink     instr,
  bsiu_result_if.source  result
);
  import bsiu_pkg::*;

  logic    in_valid;
  instr_t  in_word;
  logic    out_valid;
  result_t out_word;
  result_t exec_res;
  logic    out_ready;
  logic    in_ready;

  assign out_ready   = !out_valid || result.ready;
  assign in_ready    = !in_valid || out_ready;
  assign instr.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && instr.valid) begin
      in_word.opcode         <= instr.opcode;
      in_word.prog_counter   <= instr.prog_counter;
      in_word.stack_ptr      <= instr.stack_ptr;
      in_word.zero_flag      <= instr.zero_flag;
      in_word.carry_flag     <= instr.carry_flag;
      in_word.immediate_word <= instr.immediate_word;
      in_word.stack_word     <= instr.stack_word;
      in_word.pair_af        <= instr.pair_af;
      in_word.pair_bc        <= instr.pair_bc;
      in_word.pair_de        <= instr.pair_de;
      in_word.pair_hl        <= instr.pair_hl;
    end
  end

  bsiu_exec u_exec (
    .word (in_word),
    .res  (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_word <= exec_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.recognized     = out_word.recognized;
  assign result.next_pc        = out_word.next_pc;
  assign result.pc_final       = out_word.pc_final;
  assign result.next_sp        = out_word.next_sp;
  assign result.stack_write    = out_word.stack_write;
  assign result.write_word     = out_word.write_word;
  assign result.pair_load      = out_word.pair_load;
  assign result.pair_select    = out_word.pair_select;
  assign result.pair_value     = out_word.pair_value;
  assign result.cycle_count    = out_word.cycle_count;
  assign result.irq_enable_set = out_word.irq_enable_set;

  // a push and a pop never come from the same word
  a_write_xor_load: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.stack_write && out_word.pair_load))
    else $error("stack write and pair load together");

  // unknown opcodes charge nothing and move nothing
  a_unrecognized_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.recognized) |->
      (out_word.cycle_count == 6'd0 && !out_word.pc_final && !out_word.stack_write))
    else $error("unrecognized opcode with side effects");

  // interrupt re-enable only with a final return address
  a_reti_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.irq_enable_set) |-> out_word.pc_final)
    else $error("interrupt enable without final pc");

  // stalling at the input means both stages are full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_valid && out_valid && !result.ready))
    else $error("input stalled with a free stage");

  // a word in the input stage moves into the result register whenever the result register can take it
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_ready) |=> out_valid)
    else $error("word lost between stages");

endmodule

FILE: sv/bsiu_exec.sv
// decode and execute of one control-flow or stack instruction word
// depends on bsiu_pkg for word types and opcode codes
module bsiu_exec (
  input  bsiu_pkg::instr_t  word,
  output bsiu_pkg::result_t res
);
  import bsiu_pkg::*;

  logic        cond;
  logic [7:0]  op;
  logic [15:0] rel_off;
  logic [15:0] sp_dec;
  logic [15:0] sp_inc;
  logic [15:0] pair_sel_val;

  assign op      = word.opcode;
  assign rel_off = {{8{word.immediate_word[7]}}, word.immediate_word[7:0]};
  assign sp_dec  = word.stack_ptr - 16'd2;
  assign sp_inc  = word.stack_ptr + 16'd2;

  always_comb begin
    case (op[4:3])
      CC_NZ:   cond = !word.zero_flag;
      CC_Z:    cond = word.zero_flag;
      CC_NC:   cond = !word.carry_flag;
      CC_C:    cond = word.carry_flag;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    case (op[5:4])
      PAIR_BC: pair_sel_val = word.pair_bc;
      PAIR_DE: pair_sel_val = word.pair_de;
      PAIR_HL: pair_sel_val = word.pair_hl;
      PAIR_AF: pair_sel_val = word.pair_af;
      default: pair_sel_val = word.pair_bc;
    endcase
  end

  always_comb begin
    res                = '0;
    res.recognized     = 1'b1;
    res.next_pc        = word.prog_counter;
    res.next_sp        = word.stack_ptr;
    if (op == OP_NOP) begin
      res.cycle_count = CYC_4;
    end else if (op == OP_JR || (op & CC_MASK) == OP_JR_CC) begin
      if (op == OP_JR || cond) begin
        res.next_pc     = word.prog_counter + rel_off;
        res.cycle_count = CYC_12;
      end else begin
        res.cycle_count = CYC_8;
      end
    end else if (op == OP_JP || (op & CC_MASK) == OP_JP_CC) begin
      if (op == OP_JP || cond) begin
        res.next_pc     = word.immediate_word;
        res.pc_final    = 1'b1;
        res.cycle_count = CYC_16;
      end else begin
        res.cycle_count = CYC_12;
      end
    end else if (op == OP_CALL || (op & CC_MASK) == OP_CALL_CC) begin
      if (op == OP_CALL || cond) begin
        res.next_sp     = sp_dec;
        res.stack_write = 1'b1;
        res.write_word  = word.prog_counter + 16'd3;
        res.next_pc     = word.immediate_word;
        res.pc_final    = 1'b1;
        res.cycle_count = CYC_24;
      end else begin
        res.cycle_count = CYC_12;
      end
    end else if (op == OP_RET || (op & CC_MASK) == OP_RET_CC) begin
      if (op == OP_RET || cond) begin
        res.next_pc     = word.stack_word;
        res.next_sp     = sp_inc;
        res.pc_final    = 1'b1;
        res.cycle_count = (op == OP_RET) ? CYC_16 : CYC_20;
      end else begin
        res.cycle_count = CYC_8;
      end
    end else if (op == OP_RETI) begin
      res.next_pc        = word.stack_word;
      res.next_sp        = sp_inc;
      res.pc_final       = 1'b1;
      res.irq_enable_set = 1'b1;
      res.cycle_count    = CYC_16;
    end else if ((op & RST_MASK) == OP_RST) begin
      res.next_sp     = sp_dec;
      res.stack_write = 1'b1;
      res.write_word  = word.prog_counter + 16'd1;
      res.next_pc     = {8'h00, op & RST_VEC};
      res.pc_final    = 1'b1;
      res.cycle_count = CYC_32;
    end else if (op == OP_JP_HL) begin
      res.next_pc     = word.pair_hl;
      res.pc_final    = 1'b1;
      res.cycle_count = CYC_4;
    end else if ((op & PAIR_MASK) == OP_PUSH) begin
      res.next_sp     = sp_dec;
      res.stack_write = 1'b1;
      res.write_word  = pair_sel_val;
      res.cycle_count = CYC_16;
    end else if ((op & PAIR_MASK) == OP_POP) begin
      res.next_sp     = sp_inc;
      res.pair_load   = 1'b1;
      res.pair_select = op[5:4];
      res.pair_value  = word.stack_word;
      res.cycle_count = CYC_12;
    end else begin
      res.recognized = 1'b0;
    end
  end

endmodule

FILE: sim/branch_stack_instruction_unit_core_tb.sv
// testbench for branch_stack_instruction_unit_core: directed and random instruction words
// checked field by field against an in-bench model of the unit
// depends on bsiu_pkg, bsiu_if and the core with its exec logic
module branch_stack_instruction_unit_core_tb;
  import bsiu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int MAX_PRINTED    = 40;
  localparam logic [7:0] OP_UNUSED = 8'hd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsiu_instr_if  instr_ch ();
  bsiu_result_if result_ch ();

  branch_stack_instruction_unit_core dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  result_t    expected_results[$];
  idle_mode_e idle_mode = IDLE_NONE;
  int         hold_left = 0;
  int         fail_count = 0;
  int         words_sent = 0;
  int         results_checked = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 9))
      0: rand16 = 16'h0000;
      1: rand16 = 16'hffff;
      default: rand16 = 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [1:0] cc;
    logic [2:0] vec;
    cc = 2'($urandom);
    vec = 3'($urandom);
    case ($urandom_range(0, 14))
      0: pick_opcode = OP_NOP;
      1: pick_opcode = OP_JR;
      2: pick_opcode = OP_JR_CC | {3'b000, cc, 3'b000};
      3: pick_opcode = OP_JP;
      4: pick_opcode = OP_JP_CC | {3'b000, cc, 3'b000};
      5: pick_opcode = OP_CALL;
      6: pick_opcode = OP_CALL_CC | {3'b000, cc, 3'b000};
      7: pick_opcode = OP_RET;
      8: pick_opcode = OP_RET_CC | {3'b000, cc, 3'b000};
      9: pick_opcode = OP_RETI;
      10: pick_opcode = OP_RST | {2'b00, vec, 3'b000};
      11: pick_opcode = OP_JP_HL;
      12: pick_opcode = ($urandom_range(0, 1) ? OP_PUSH : OP_POP) | {2'b00, cc, 4'b0000};
      default: pick_opcode = 8'($urandom);
    endcase
  endfunction

  function automatic instr_t make_instr(logic [7:0] op, logic [15:0] pc, logic [15:0] sp,
                                        logic zf, logic cf, logic [15:0] imm,
                                        logic [15:0] stw);
    instr_t w;
    w.opcode = op;
    w.prog_counter = pc;
    w.stack_ptr = sp;
    w.zero_flag = zf;
    w.carry_flag = cf;
    w.immediate_word = imm;
    w.stack_word = stw;
    w.pair_af = rand16();
    w.pair_bc = rand16();
    w.pair_de = rand16();
    w.pair_hl = rand16();
    return w;
  endfunction

  function automatic instr_t random_instr();
    return make_instr(pick_opcode(), rand16(), rand16(), 1'($urandom), 1'($urandom),
                      rand16(), rand16());
  endfunction

  function automatic result_t execute_instr(instr_t w);
    result_t    r;
    logic       take;
    logic [7:0] op;
    op = w.opcode;
    r = '0;
    r.recognized = 1'b1;
    r.next_pc = w.prog_counter;
    r.next_sp = w.stack_ptr;
    case (op[4:3])
      CC_NZ: take = !w.zero_flag;
      CC_Z: take = w.zero_flag;
      CC_NC: take = !w.carry_flag;
      default: take = w.carry_flag;
    endcase
    if (op == OP_NOP) begin
      r.cycle_count = CYC_4;
    end else if (op == OP_JR || (op & CC_MASK) == OP_JR_CC) begin
      if (op == OP_JR || take) begin
        r.next_pc = w.prog_counter + {{8{w.immediate_word[7]}}, w.immediate_word[7:0]};
        r.cycle_count = CYC_12;
      end else begin
        r.cycle_count = CYC_8;
      end
    end else if (op == OP_JP || (op & CC_MASK) == OP_JP_CC) begin
      if (op == OP_JP || take) begin
        r.next_pc = w.immediate_word;
        r.pc_final = 1'b1;
        r.cycle_count = CYC_16;
      end else begin
        r.cycle_count = CYC_12;
      end
    end else if (op == OP_CALL || (op & CC_MASK) == OP_CALL_CC) begin
      if (op == OP_CALL || take) begin
        r.next_sp = w.stack_ptr - 16'd2;
        r.stack_write = 1'b1;
        r.write_word = w.prog_counter + 16'd3;
        r.next_pc = w.immediate_word;
        r.pc_final = 1'b1;
        r.cycle_count = CYC_24;
      end else begin
        r.cycle_count = CYC_12;
      end
    end else if (op == OP_RET || (op & CC_MASK) == OP_RET_CC) begin
      if (op == OP_RET || take) begin
        r.next_pc = w.stack_word;
        r.next_sp = w.stack_ptr + 16'd2;
        r.pc_final = 1'b1;
        r.cycle_count = (op == OP_RET) ? CYC_16 : CYC_20;
      end else begin
        r.cycle_count = CYC_8;
      end
    end else if (op == OP_RETI) begin
      r.next_pc = w.stack_word;
      r.next_sp = w.stack_ptr + 16'd2;
      r.pc_final = 1'b1;
      r.irq_enable_set = 1'b1;
      r.cycle_count = CYC_16;
    end else if ((op & RST_MASK) == OP_RST) begin
      r.next_sp = w.stack_ptr - 16'd2;
      r.stack_write = 1'b1;
      r.write_word = w.prog_counter + 16'd1;
      r.next_pc = {8'h00, op & RST_VEC};
      r.pc_final = 1'b1;
      r.cycle_count = CYC_32;
    end else if (op == OP_JP_HL) begin
      r.next_pc = w.pair_hl;
      r.pc_final = 1'b1;
      r.cycle_count = CYC_4;
    end else if ((op & PAIR_MASK) == OP_PUSH) begin
      r.next_sp = w.stack_ptr - 16'd2;
      r.stack_write = 1'b1;
      case (op[5:4])
        PAIR_BC: r.write_word = w.pair_bc;
        PAIR_DE: r.write_word = w.pair_de;
        PAIR_HL: r.write_word = w.pair_hl;
        default: r.write_word = w.pair_af;
      endcase
      r.cycle_count = CYC_16;
    end else if ((op & PAIR_MASK) == OP_POP) begin
      r.next_sp = w.stack_ptr + 16'd2;
      r.pair_load = 1'b1;
      r.pair_select = op[5:4];
      r.pair_value = w.stack_word;
      r.cycle_count = CYC_12;
    end else begin
      r.recognized = 1'b0;
    end
    return r;
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SEND: sender_idles = ($urandom_range(0, 99) < 85);
      IDLE_BOTH: sender_idles = ($urandom_range(0, 99) < 12);
      default: sender_idles = 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECV: receiver_stalls = ($urandom_range(0, 99) < 85);
      IDLE_BOTH: receiver_stalls = ($urandom_range(0, 99) < 12);
      default: receiver_stalls = 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int idx, input logic [15:0] got,
                             input logic [15:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("result %0d %s got %h expected %h", idx, name, got, exp));
  endtask

  task automatic compare_result(input result_t got, input result_t exp);
    check_field("recognized", results_checked, 16'(got.recognized), 16'(exp.recognized));
    check_field("next_pc", results_checked, got.next_pc, exp.next_pc);
    check_field("pc_final", results_checked, 16'(got.pc_final), 16'(exp.pc_final));
    check_field("next_sp", results_checked, got.next_sp, exp.next_sp);
    check_field("stack_write", results_checked, 16'(got.stack_write),
                16'(exp.stack_write));
    check_field("write_word", results_checked, got.write_word, exp.write_word);
    check_field("pair_load", results_checked, 16'(got.pair_load), 16'(exp.pair_load));
    check_field("pair_select", results_checked, 16'(got.pair_select),
                16'(exp.pair_select));
    check_field("pair_value", results_checked, got.pair_value, exp.pair_value);
    check_field("cycle_count", results_checked, 16'(got.cycle_count),
                16'(exp.cycle_count));
    check_field("irq_enable_set", results_checked, 16'(got.irq_enable_set),
                16'(exp.irq_enable_set));
  endtask

  // result check first, then the new word's prediction
  always @(posedge clk) begin
    result_t got;
    instr_t  seen;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = {result_ch.recognized, result_ch.next_pc, result_ch.pc_final,
               result_ch.next_sp, result_ch.stack_write, result_ch.write_word,
               result_ch.pair_load, result_ch.pair_select, result_ch.pair_value,
               result_ch.cycle_count, result_ch.irq_enable_set};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected, next_pc %h",
                                    got.next_pc));
        end else begin
          compare_result(got, expected_results.pop_front());
        end
        results_checked++;
      end
      if (instr_ch.valid && instr_ch.ready) begin
        seen = {instr_ch.opcode, instr_ch.prog_counter, instr_ch.stack_ptr,
                instr_ch.zero_flag, instr_ch.carry_flag, instr_ch.immediate_word,
                instr_ch.stack_word, instr_ch.pair_af, instr_ch.pair_bc,
                instr_ch.pair_de, instr_ch.pair_hl};
        expected_results.push_back(execute_instr(seen));
        words_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_ch.ready <= !receiver_stalls();
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_instr(input instr_t w);
    @(negedge clk);
    while (sender_idles()) begin
      instr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.opcode <= w.opcode;
    instr_ch.prog_counter <= w.prog_counter;
    instr_ch.stack_ptr <= w.stack_ptr;
    instr_ch.zero_flag <= w.zero_flag;
    instr_ch.carry_flag <= w.carry_flag;
    instr_ch.immediate_word <= w.immediate_word;
    instr_ch.stack_word <= w.stack_word;
    instr_ch.pair_af <= w.pair_af;
    instr_ch.pair_bc <= w.pair_bc;
    instr_ch.pair_de <= w.pair_de;
    instr_ch.pair_hl <= w.pair_hl;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
  endtask

  task automatic hold_sender_until_drained();
    @(negedge clk);
    instr_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int c;
    idle_mode = IDLE_NONE;
    send_instr(make_instr(OP_NOP, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_JR, 16'hffff, 16'h1000, 1'b0, 1'b0, 16'h007f, 16'h0000));
    send_instr(make_instr(OP_JR, 16'h0000, 16'h1000, 1'b1, 1'b1, 16'hff80, 16'hffff));
    for (c = 0; c < 4; c++)
      send_instr(make_instr(OP_JR_CC | {3'b000, 2'(c), 3'b000}, rand16(), rand16(),
                            1'b1, 1'b0, rand16(), rand16()));
    send_instr(make_instr(OP_JP, 16'h0100, 16'hfffe, 1'b0, 1'b0, 16'hffff, 16'h0000));
    send_instr(make_instr(OP_JP_CC | {3'b000, CC_Z, 3'b000}, 16'h0200, 16'hfffe, 1'b1, 1'b0,
                          16'h8000, 16'h0000));
    send_instr(make_instr(OP_JP_CC | {3'b000, CC_NC, 3'b000}, 16'h0200, 16'hfffe, 1'b0,
                          1'b1, 16'h8000, 16'h0000));
    send_instr(make_instr(OP_CALL, 16'hfffe, 16'h0000, 1'b0, 1'b0, 16'h4000, 16'h0000));
    send_instr(make_instr(OP_CALL_CC | {3'b000, CC_C, 3'b000}, 16'h1234, 16'h0001, 1'b0,
                          1'b1, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_CALL_CC | {3'b000, CC_NZ, 3'b000}, 16'h1234, 16'h0001, 1'b1,
                          1'b0, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_RET, 16'h2000, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'habcd));
    send_instr(make_instr(OP_RET_CC | {3'b000, CC_NZ, 3'b000}, 16'h2000, 16'hfffe, 1'b0,
                          1'b0, 16'h0000, 16'hffff));
    send_instr(make_instr(OP_RET_CC | {3'b000, CC_C, 3'b000}, 16'h2000, 16'hfffe, 1'b1,
                          1'b0, 16'h0000, 16'hffff));
    send_instr(make_instr(OP_RETI, 16'h3000, 16'hfffe, 1'b1, 1'b1, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_RST | RST_VEC, 16'hffff, 16'h0000, 1'b0, 1'b0, 16'hffff,
                          16'h0000));
    send_instr(make_instr(OP_RST, 16'h1234, 16'h0001, 1'b1, 1'b1, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_JP_HL, 16'h4000, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_PUSH | {2'b00, PAIR_BC, 4'b0000}, 16'h5000, 16'h0001, 1'b0,
                          1'b0, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_PUSH | {2'b00, PAIR_AF, 4'b0000}, 16'h5000, 16'h0000, 1'b0,
                          1'b0, 16'h0000, 16'h0000));
    send_instr(make_instr(OP_POP | {2'b00, PAIR_HL, 4'b0000}, 16'h6000, 16'hfffe, 1'b0,
                          1'b0, 16'h0000, 16'h1357));
    send_instr(make_instr(OP_POP | {2'b00, PAIR_AF, 4'b0000}, 16'h6000, 16'hffff, 1'b0,
                          1'b0, 16'h0000, 16'hffff));
    send_instr(make_instr(OP_UNUSED, 16'h7000, 16'h7000, 1'b1, 1'b1, 16'hffff, 16'hffff));
  endtask

  task automatic test_random(input idle_mode_e mode, input int count);
    idle_mode = mode;
    repeat (count) send_instr(random_instr());
  endtask

  // long result-side hold while words keep coming, so the input side backs up
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    hold_left = HOLD_CYCLES;
    repeat (40) send_instr(random_instr());
  endtask

  task automatic test_drain_pause();
    idle_mode = IDLE_BOTH;
    repeat (20) send_instr(random_instr());
    hold_sender_until_drained();
    repeat (20) send_instr(random_instr());
  endtask

  initial begin
    instr_ch.valid = 1'b0;
    instr_ch.opcode = '0;
    instr_ch.prog_counter = '0;
    instr_ch.stack_ptr = '0;
    instr_ch.zero_flag = 1'b0;
    instr_ch.carry_flag = 1'b0;
    instr_ch.immediate_word = '0;
    instr_ch.stack_word = '0;
    instr_ch.pair_af = '0;
    instr_ch.pair_bc = '0;
    instr_ch.pair_de = '0;
    instr_ch.pair_hl = '0;
    result_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(IDLE_NONE, 250);
    test_random(IDLE_SEND, 200);
    test_random(IDLE_RECV, 250);
    test_random(IDLE_BOTH, 250);
    test_backpressure();
    test_drain_pause();

    hold_sender_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    $display("sent %0d instruction words, checked %0d result words, %0d mismatches",
             words_sent, results_checked, fail_count);
    $display("covered all opcode groups, taken and untaken conditions, four idle phases,");
    $display("a long result-side hold and a full drain pause");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
